// ===== src/assert_macros.svh =====
// Assertion macros used by the port-level checker.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every sampled edge.
`define DLS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition in one cycle implies a condition in the next cycle.
`define DLS_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== src/dls_pkg.sv =====
// Daily level statistics: shared field widths and record kind codes.
// No dependencies.
`timescale 1ns / 1ps

package dls_pkg;

  localparam int DAY_W     = 16;
  localparam int TIME_W    = 17;
  localparam int LEVEL_W   = 16;
  localparam int KIND_W    = 2;
  localparam int OCNT_W    = 13;
  localparam int OSUM_W    = 28;
  localparam int DIV_STEPS = LEVEL_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_DAY = 2'd0,
    KIND_MAX = 2'd1,
    KIND_MIN = 2'd2
  } kind_t;

endpackage

// ===== src/daily_level_statistics.sv =====
// Daily level statistics: per-day count/sum/min/max/mean records and overall extremes.
// Front: close (on a day change) and update per sample; final, xmax, xmin at end of data.
// Back: day records take a 16-step divide before the output register; extremes skip it.
// Jobs wait in a 4-entry queue; the front stalls while it is full.
// The back takes no new job until the output register has taken the current one.
// Synchronous active-low reset clears all statistics and both handshakes.
`timescale 1ns / 1ps

module daily_level_statistics #(
  parameter int MAX_PER_DAY = 4096
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic        [dls_pkg::DAY_W-1:0]   in_day,
  input  logic        [dls_pkg::TIME_W-1:0]  in_time_of_day,
  input  logic signed [dls_pkg::LEVEL_W-1:0] in_level,
  input  logic                               in_end_of_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic        [dls_pkg::KIND_W-1:0]  out_kind,
  output logic        [dls_pkg::DAY_W-1:0]   out_record_day,
  output logic        [dls_pkg::TIME_W-1:0]  out_record_time,
  output logic        [dls_pkg::OCNT_W-1:0]  out_sample_count,
  output logic signed [dls_pkg::OSUM_W-1:0]  out_level_sum,
  output logic signed [dls_pkg::LEVEL_W-1:0] out_low_level,
  output logic signed [dls_pkg::LEVEL_W-1:0] out_high_level,
  output logic        [dls_pkg::LEVEL_W-1:0] out_level_range,
  output logic signed [dls_pkg::LEVEL_W-1:0] out_mean_level,
  output logic                               out_overflow,
  output logic                               out_last
);

  localparam int CNT_W       = $clog2(MAX_PER_DAY + 1);
  localparam int SUM_W       = CNT_W + dls_pkg::LEVEL_W;
  localparam int JOB_W       = dls_pkg::KIND_W + dls_pkg::DAY_W + dls_pkg::TIME_W + CNT_W +
                               SUM_W + 2 * dls_pkg::LEVEL_W + 2;
  localparam int QUEUE_DEPTH = 4;

  logic             push;
  logic [JOB_W-1:0] push_data;
  logic             full;
  logic             pop;
  logic [JOB_W-1:0] pop_data;
  logic             empty;

  dls_front #(
    .MAX_PER_DAY (MAX_PER_DAY),
    .CNT_W       (CNT_W),
    .SUM_W       (SUM_W),
    .JOB_W       (JOB_W)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_day         (in_day),
    .in_time_of_day (in_time_of_day),
    .in_level       (in_level),
    .in_end_of_data (in_end_of_data),
    .push           (push),
    .push_data      (push_data),
    .full           (full)
  );

  dls_fifo #(
    .DATA_W (JOB_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  dls_back #(
    .CNT_W (CNT_W),
    .SUM_W (SUM_W),
    .JOB_W (JOB_W)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .pop              (pop),
    .pop_data         (pop_data),
    .empty            (empty),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_record_day   (out_record_day),
    .out_record_time  (out_record_time),
    .out_sample_count (out_sample_count),
    .out_level_sum    (out_level_sum),
    .out_low_level    (out_low_level),
    .out_high_level   (out_high_level),
    .out_level_range  (out_level_range),
    .out_mean_level   (out_mean_level),
    .out_overflow     (out_overflow),
    .out_last         (out_last)
  );

endmodule

// ===== src/dls_fifo.sv =====
// Small register queue carrying record jobs from the front to the back.
// Depends on nothing; width and depth come from the instantiating level.
`timescale 1ns / 1ps

module dls_fifo #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output logic              empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [FILL_W-1:0] fill_r;
  logic              do_push;
  logic              do_pop;

  assign full     = fill_r == FILL_W'(DEPTH);
  assign empty    = fill_r == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + FILL_W'(1);
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - FILL_W'(1);
      end
    end
  end

endmodule

// ===== src/dls_front.sv =====
// Front end: takes samples, keeps per-day and overall statistics, queues record jobs.
// Depends on dls_pkg.
`timescale 1ns / 1ps

module dls_front #(
  parameter int MAX_PER_DAY = 4096,
  parameter int CNT_W       = 13,
  parameter int SUM_W       = 29,
  parameter int JOB_W       = 102
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic        [dls_pkg::DAY_W-1:0]   in_day,
  input  logic        [dls_pkg::TIME_W-1:0]  in_time_of_day,
  input  logic signed [dls_pkg::LEVEL_W-1:0] in_level,
  input  logic                               in_end_of_data,
  output logic                               push,
  output logic        [JOB_W-1:0]            push_data,
  input  logic                               full
);

  typedef struct packed {
    dls_pkg::kind_t                     kind;
    logic        [dls_pkg::DAY_W-1:0]   day;
    logic        [dls_pkg::TIME_W-1:0]  tod;
    logic        [CNT_W-1:0]            cnt;
    logic signed [SUM_W-1:0]            sum;
    logic signed [dls_pkg::LEVEL_W-1:0] lo;
    logic signed [dls_pkg::LEVEL_W-1:0] hi;
    logic                               ovf;
    logic                               last;
  } job_t;

  typedef enum logic [5:0] {
    F_IDLE   = 6'b000001,
    F_CLOSE  = 6'b000010,
    F_UPDATE = 6'b000100,
    F_FINAL  = 6'b001000,
    F_XMAX   = 6'b010000,
    F_XMIN   = 6'b100000
  } fstate_t;

  fstate_t state_r, state_nxt;

  logic        [dls_pkg::DAY_W-1:0]   s_day_r;
  logic        [dls_pkg::TIME_W-1:0]  s_time_r;
  logic signed [dls_pkg::LEVEL_W-1:0] s_level_r;
  logic                               s_eod_r;
  logic                               open_r;

  logic                               started_r;
  logic        [dls_pkg::DAY_W-1:0]   cur_day_r;
  logic        [CNT_W-1:0]            cnt_r;
  logic signed [SUM_W-1:0]            sum_r;
  logic signed [dls_pkg::LEVEL_W-1:0] dmin_r;
  logic signed [dls_pkg::LEVEL_W-1:0] dmax_r;
  logic                               dovf_r;
  logic        [CNT_W-1:0]            most_r;
  logic signed [dls_pkg::LEVEL_W-1:0] omax_r;
  logic        [dls_pkg::DAY_W-1:0]   omax_day_r;
  logic        [dls_pkg::TIME_W-1:0]  omax_time_r;
  logic signed [dls_pkg::LEVEL_W-1:0] omin_r;
  logic        [dls_pkg::DAY_W-1:0]   omin_day_r;
  logic        [dls_pkg::TIME_W-1:0]  omin_time_r;

  logic        [CNT_W-1:0]            b_cnt;
  logic signed [SUM_W-1:0]            b_sum;
  logic signed [dls_pkg::LEVEL_W-1:0] b_min;
  logic signed [dls_pkg::LEVEL_W-1:0] b_max;
  logic                               b_ovf;
  logic signed [dls_pkg::LEVEL_W-1:0] b_omax;
  logic        [dls_pkg::DAY_W-1:0]   b_omax_day;
  logic        [dls_pkg::TIME_W-1:0]  b_omax_time;
  logic signed [dls_pkg::LEVEL_W-1:0] b_omin;
  logic        [dls_pkg::DAY_W-1:0]   b_omin_day;
  logic        [dls_pkg::TIME_W-1:0]  b_omin_time;
  logic                               room;

  logic        [CNT_W-1:0]            cnt_nxt;
  logic signed [SUM_W-1:0]            sum_nxt;
  logic signed [dls_pkg::LEVEL_W-1:0] dmin_nxt;
  logic signed [dls_pkg::LEVEL_W-1:0] dmax_nxt;
  logic                               dovf_nxt;
  logic        [CNT_W-1:0]            most_nxt;
  logic                               take_max;
  logic                               take_min;

  job_t job;
  logic in_xfer;

  assign in_ready = state_r == F_IDLE;
  assign in_xfer  = in_valid && in_ready;

  // Statistics update for the held sample; a new day starts from the sample itself.
  always_comb begin
    b_cnt       = open_r ? '0 : cnt_r;
    b_sum       = open_r ? '0 : sum_r;
    b_min       = open_r ? s_level_r : dmin_r;
    b_max       = open_r ? s_level_r : dmax_r;
    b_ovf       = open_r ? 1'b0 : dovf_r;
    b_omax      = started_r ? omax_r : s_level_r;
    b_omax_day  = started_r ? omax_day_r : s_day_r;
    b_omax_time = started_r ? omax_time_r : s_time_r;
    b_omin      = started_r ? omin_r : s_level_r;
    b_omin_day  = started_r ? omin_day_r : s_day_r;
    b_omin_time = started_r ? omin_time_r : s_time_r;
    room        = b_cnt < CNT_W'(MAX_PER_DAY);
    cnt_nxt     = room ? b_cnt + CNT_W'(1) : b_cnt;
    sum_nxt     = room ? b_sum + SUM_W'(s_level_r) : b_sum;
    dovf_nxt    = b_ovf | ~room;
    dmin_nxt    = (s_level_r < b_min) ? s_level_r : b_min;
    dmax_nxt    = (s_level_r > b_max) ? s_level_r : b_max;
    most_nxt    = (room && (cnt_nxt > most_r)) ? cnt_nxt : most_r;
    take_max    = s_level_r > b_omax;
    take_min    = s_level_r < b_omin;
  end

  always_comb begin
    job = '{kind: dls_pkg::KIND_DAY, day: cur_day_r, tod: '0, cnt: cnt_r, sum: sum_r,
            lo: dmin_r, hi: dmax_r, ovf: dovf_r, last: 1'b0};
    push = 1'b0;
    case (state_r)
      F_CLOSE: begin
        push     = 1'b1;
        job.last = !s_eod_r;
      end
      F_FINAL: begin
        push = 1'b1;
      end
      F_XMAX: begin
        push = 1'b1;
        job  = '{kind: dls_pkg::KIND_MAX, day: omax_day_r, tod: omax_time_r, cnt: most_r,
                 sum: '0, lo: '0, hi: omax_r, ovf: 1'b0, last: 1'b0};
      end
      F_XMIN: begin
        push = 1'b1;
        job  = '{kind: dls_pkg::KIND_MIN, day: omin_day_r, tod: omin_time_r, cnt: most_r,
                 sum: '0, lo: omin_r, hi: '0, ovf: 1'b0, last: 1'b1};
      end
      default: begin
        push = 1'b0;
      end
    endcase
    push_data = job;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          state_nxt = (started_r && (in_day != cur_day_r)) ? F_CLOSE : F_UPDATE;
        end
      end
      F_CLOSE: begin
        if (!full) begin
          state_nxt = F_UPDATE;
        end
      end
      F_UPDATE: begin
        state_nxt = s_eod_r ? F_FINAL : F_IDLE;
      end
      F_FINAL: begin
        if (!full) begin
          state_nxt = F_XMAX;
        end
      end
      F_XMAX: begin
        if (!full) begin
          state_nxt = F_XMIN;
        end
      end
      F_XMIN: begin
        if (!full) begin
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s_day_r   <= in_day;
      s_time_r  <= in_time_of_day;
      s_level_r <= in_level;
      s_eod_r   <= in_end_of_data;
      open_r    <= !started_r || (in_day != cur_day_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= F_IDLE;
      started_r   <= 1'b0;
      cur_day_r   <= '0;
      cnt_r       <= '0;
      sum_r       <= '0;
      dmin_r      <= '0;
      dmax_r      <= '0;
      dovf_r      <= 1'b0;
      most_r      <= '0;
      omax_r      <= '0;
      omax_day_r  <= '0;
      omax_time_r <= '0;
      omin_r      <= '0;
      omin_day_r  <= '0;
      omin_time_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == F_UPDATE) begin
        started_r   <= 1'b1;
        cur_day_r   <= s_day_r;
        cnt_r       <= cnt_nxt;
        sum_r       <= sum_nxt;
        dmin_r      <= dmin_nxt;
        dmax_r      <= dmax_nxt;
        dovf_r      <= dovf_nxt;
        most_r      <= most_nxt;
        omax_r      <= take_max ? s_level_r : b_omax;
        omax_day_r  <= take_max ? s_day_r : b_omax_day;
        omax_time_r <= take_max ? s_time_r : b_omax_time;
        omin_r      <= take_min ? s_level_r : b_omin;
        omin_day_r  <= take_min ? s_day_r : b_omin_day;
        omin_time_r <= take_min ? s_time_r : b_omin_time;
      end
      // end of series: back to the reset state
      if ((state_r == F_XMIN) && !full) begin
        started_r   <= 1'b0;
        cur_day_r   <= '0;
        cnt_r       <= '0;
        sum_r       <= '0;
        dmin_r      <= '0;
        dmax_r      <= '0;
        dovf_r      <= 1'b0;
        most_r      <= '0;
        omax_r      <= '0;
        omax_day_r  <= '0;
        omax_time_r <= '0;
        omin_r      <= '0;
        omin_day_r  <= '0;
        omin_time_r <= '0;
      end
    end
  end

endmodule

// ===== src/dls_back.sv =====
// Back end: pops record jobs, divides sum by count for day records, drives the output register.
// Depends on dls_pkg.
`timescale 1ns / 1ps

module dls_back #(
  parameter int CNT_W = 13,
  parameter int SUM_W = 29,
  parameter int JOB_W = 102
) (
  input  logic                               clk,
  input  logic                               rst_n,
  output logic                               pop,
  input  logic        [JOB_W-1:0]            pop_data,
  input  logic                               empty,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic        [dls_pkg::KIND_W-1:0]  out_kind,
  output logic        [dls_pkg::DAY_W-1:0]   out_record_day,
  output logic        [dls_pkg::TIME_W-1:0]  out_record_time,
  output logic        [dls_pkg::OCNT_W-1:0]  out_sample_count,
  output logic signed [dls_pkg::OSUM_W-1:0]  out_level_sum,
  output logic signed [dls_pkg::LEVEL_W-1:0] out_low_level,
  output logic signed [dls_pkg::LEVEL_W-1:0] out_high_level,
  output logic        [dls_pkg::LEVEL_W-1:0] out_level_range,
  output logic signed [dls_pkg::LEVEL_W-1:0] out_mean_level,
  output logic                               out_overflow,
  output logic                               out_last
);

  localparam int LW     = dls_pkg::LEVEL_W;
  localparam int STEP_W = $clog2(dls_pkg::DIV_STEPS);

  typedef struct packed {
    dls_pkg::kind_t                     kind;
    logic        [dls_pkg::DAY_W-1:0]   day;
    logic        [dls_pkg::TIME_W-1:0]  tod;
    logic        [CNT_W-1:0]            cnt;
    logic signed [SUM_W-1:0]            sum;
    logic signed [dls_pkg::LEVEL_W-1:0] lo;
    logic signed [dls_pkg::LEVEL_W-1:0] hi;
    logic                               ovf;
    logic                               last;
  } job_t;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_DIV  = 3'b010,
    B_OUT  = 3'b100
  } bstate_t;

  bstate_t state_r, state_nxt;

  job_t              job_r;
  job_t              job_in;
  logic [CNT_W-1:0]  rem_r;
  logic [LW-1:0]     dq_r;
  logic [STEP_W-1:0] step_r;
  logic              out_valid_r;

  logic [SUM_W-1:0]  mag;
  logic [CNT_W:0]    trial;
  logic              ge;
  logic              load_out;
  logic              is_day;
  logic [LW-1:0]     mean_val;

  assign job_in    = job_t'(pop_data);
  assign pop       = (state_r == B_IDLE) && !empty;
  assign mag       = job_in.sum[SUM_W-1] ? SUM_W'(-job_in.sum) : SUM_W'(job_in.sum);
  assign trial     = {rem_r, dq_r[LW-1]};
  assign ge        = trial >= {1'b0, job_r.cnt};
  assign load_out  = (state_r == B_OUT) && (!out_valid_r || out_ready);
  assign is_day    = job_r.kind == dls_pkg::KIND_DAY;
  assign mean_val  = job_r.sum[SUM_W-1] ? LW'(-dq_r) : dq_r;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (!empty) begin
          state_nxt = (job_in.kind == dls_pkg::KIND_DAY) ? B_DIV : B_OUT;
        end
      end
      B_DIV: begin
        if (step_r == STEP_W'(dls_pkg::DIV_STEPS - 1)) begin
          state_nxt = B_OUT;
        end
      end
      B_OUT: begin
        if (load_out) begin
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  // Restoring divide of |sum| by count; quotient fits the level width.
  always_ff @(posedge clk) begin
    if (pop) begin
      job_r  <= job_in;
      rem_r  <= mag[SUM_W-1:LW];
      dq_r   <= mag[LW-1:0];
      step_r <= '0;
    end else if (state_r == B_DIV) begin
      rem_r  <= ge ? CNT_W'(trial - {1'b0, job_r.cnt}) : trial[CNT_W-1:0];
      dq_r   <= {dq_r[LW-2:0], ge};
      step_r <= step_r + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_kind         <= job_r.kind;
      out_record_day   <= job_r.day;
      out_record_time  <= job_r.tod;
      out_sample_count <= dls_pkg::OCNT_W'(job_r.cnt);
      out_level_sum    <= dls_pkg::OSUM_W'(job_r.sum);
      out_low_level    <= job_r.lo;
      out_high_level   <= job_r.hi;
      out_level_range  <= is_day ? LW'(job_r.hi - job_r.lo) : '0;
      out_mean_level   <= (is_day && (job_r.cnt != '0)) ? mean_val : '0;
      out_overflow     <= job_r.ovf;
      out_last         <= job_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ===== src/dls_checker.sv =====
// Port-level checker for daily_level_statistics, attached by bind.
// Depends on dls_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dls_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic        [dls_pkg::KIND_W-1:0]  out_kind,
  input logic        [dls_pkg::DAY_W-1:0]   out_record_day,
  input logic        [dls_pkg::TIME_W-1:0]  out_record_time,
  input logic signed [dls_pkg::OSUM_W-1:0]  out_level_sum,
  input logic signed [dls_pkg::LEVEL_W-1:0] out_low_level,
  input logic signed [dls_pkg::LEVEL_W-1:0] out_high_level,
  input logic        [dls_pkg::LEVEL_W-1:0] out_level_range,
  input logic signed [dls_pkg::LEVEL_W-1:0] out_mean_level,
  input logic                               out_overflow,
  input logic                               out_last
);

  logic stall;
  logic is_day;
  logic is_max;
  logic is_min;

  assign stall  = out_valid && !out_ready;
  assign is_day = out_kind == dls_pkg::KIND_DAY;
  assign is_max = out_kind == dls_pkg::KIND_MAX;
  assign is_min = out_kind == dls_pkg::KIND_MIN;

  `DLS_ASSERT_NEXT(a_out_hold, stall, out_valid, "out_valid dropped while stalled")
  `DLS_ASSERT_NEXT(a_out_stable, stall, $stable(out_record_day) && $stable(out_kind), "stalled transfer changed")
  `DLS_ASSERT(a_min_last, !(out_valid && is_min) || out_last, "overall minimum record not marked last")
  `DLS_ASSERT(a_max_fields, !(out_valid && is_max) || (out_level_sum == '0 && out_level_range == '0 && out_mean_level == '0 && !out_overflow && !out_last), "bad overall maximum record")
  `DLS_ASSERT(a_day_range, !(out_valid && is_day) || (out_record_time == '0 && out_level_range == 16'(out_high_level - out_low_level)), "day record range mismatch")

endmodule

bind daily_level_statistics dls_checker u_dls_checker (.*);

// ===== verif/testbench.sv =====
// Testbench for daily_level_statistics: per-day records and overall extremes
// checked against an in-bench predictor, with random idling on both channels.
// Depends on dls_pkg and the daily_level_statistics RTL.
`timescale 1ns / 1ps

typedef struct {
  dls_pkg::kind_t                      kind;
  logic        [dls_pkg::DAY_W-1:0]    record_day;
  logic        [dls_pkg::TIME_W-1:0]   record_time;
  logic        [dls_pkg::OCNT_W-1:0]   sample_count;
  logic signed [dls_pkg::OSUM_W-1:0]   level_sum;
  logic signed [dls_pkg::LEVEL_W-1:0]  low_level;
  logic signed [dls_pkg::LEVEL_W-1:0]  high_level;
  logic        [dls_pkg::LEVEL_W-1:0]  level_range;
  logic signed [dls_pkg::LEVEL_W-1:0]  mean_level;
  logic                                overflow;
  logic                                last;
} day_record_t;

class day_stats_predictor;
  int limit;
  int mismatches;
  day_record_t expected_records[$];

  bit                        started;
  logic [dls_pkg::DAY_W-1:0] cur_day;
  int                        cnt;
  int                        sum;
  int                        lo;
  int                        hi;
  bit                        ovf;
  int                        most_count;
  int                        high_mark;
  logic [dls_pkg::DAY_W-1:0] high_day;
  logic [dls_pkg::TIME_W-1:0] high_time;
  int                        low_mark;
  logic [dls_pkg::DAY_W-1:0] low_day;
  logic [dls_pkg::TIME_W-1:0] low_time;

  function new(int per_day_limit);
    limit = per_day_limit;
    mismatches = 0;
    clear();
  endfunction

  function void clear();
    started = 0;
    cur_day = '0;
    cnt = 0;
    sum = 0;
    lo = 0;
    hi = 0;
    ovf = 0;
    most_count = 0;
    high_mark = 0;
    high_day = '0;
    high_time = '0;
    low_mark = 0;
    low_day = '0;
    low_time = '0;
  endfunction

  function void open_day(logic [dls_pkg::DAY_W-1:0] d, int lv);
    cur_day = d;
    cnt = 0;
    sum = 0;
    lo = lv;
    hi = lv;
    ovf = 0;
  endfunction

  function day_record_t day_summary();
    day_record_t r;
    r.kind = dls_pkg::KIND_DAY;
    r.record_day = cur_day;
    r.record_time = '0;
    r.sample_count = dls_pkg::OCNT_W'(cnt);
    r.level_sum = dls_pkg::OSUM_W'(sum);
    r.low_level = dls_pkg::LEVEL_W'(lo);
    r.high_level = dls_pkg::LEVEL_W'(hi);
    r.level_range = dls_pkg::LEVEL_W'(hi - lo);
    r.mean_level = (cnt != 0) ? dls_pkg::LEVEL_W'(sum / cnt) : '0;
    r.overflow = ovf;
    r.last = 1'b0;
    return r;
  endfunction

  function day_record_t extreme(dls_pkg::kind_t k);
    day_record_t r;
    r.kind = k;
    r.sample_count = dls_pkg::OCNT_W'(most_count);
    r.level_sum = '0;
    r.level_range = '0;
    r.mean_level = '0;
    r.overflow = 1'b0;
    r.last = 1'b0;
    if (k == dls_pkg::KIND_MAX) begin
      r.record_day = high_day;
      r.record_time = high_time;
      r.high_level = dls_pkg::LEVEL_W'(high_mark);
      r.low_level = '0;
    end else begin
      r.record_day = low_day;
      r.record_time = low_time;
      r.low_level = dls_pkg::LEVEL_W'(low_mark);
      r.high_level = '0;
    end
    return r;
  endfunction

  function void take_sample(logic [dls_pkg::DAY_W-1:0] d, logic [dls_pkg::TIME_W-1:0] t,
                            logic signed [dls_pkg::LEVEL_W-1:0] lvl, logic eod);
    day_record_t made[$];
    int lv;
    lv = int'(lvl);
    if (!started) begin
      started = 1;
      open_day(d, lv);
      high_mark = lv;
      high_day = d;
      high_time = t;
      low_mark = lv;
      low_day = d;
      low_time = t;
    end else if (d != cur_day) begin
      made = {made, day_summary()};
      open_day(d, lv);
    end
    if (lv > high_mark) begin
      high_mark = lv;
      high_day = d;
      high_time = t;
    end
    if (lv < low_mark) begin
      low_mark = lv;
      low_day = d;
      low_time = t;
    end
    if (lv < lo) lo = lv;
    if (lv > hi) hi = lv;
    if (cnt < limit) begin
      cnt++;
      sum += lv;
      if (cnt > most_count) most_count = cnt;
    end else begin
      ovf = 1;
    end
    if (eod) begin
      made = {made, day_summary()};
      made = {made, extreme(dls_pkg::KIND_MAX)};
      made = {made, extreme(dls_pkg::KIND_MIN)};
      clear();
    end
    if (made.size() > 0) made[made.size()-1].last = 1'b1;
    foreach (made[i]) expected_records = {expected_records, made[i]};
  endfunction

  function int outstanding();
    return expected_records.size();
  endfunction

  function void compare(string field, logic signed [63:0] want, logic signed [63:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      mismatches++;
    end
  endfunction

  function void check_record(day_record_t got);
    day_record_t want;
    if (expected_records.size() == 0) begin
      $display("%0t: unexpected record: expected none, got kind %0d day %0d",
               $time, got.kind, got.record_day);
      mismatches++;
      return;
    end
    want = expected_records.pop_front();
    compare("kind", 64'(want.kind), 64'(got.kind));
    compare("record_day", 64'(want.record_day), 64'(got.record_day));
    compare("record_time", 64'(want.record_time), 64'(got.record_time));
    compare("sample_count", 64'(want.sample_count), 64'(got.sample_count));
    compare("level_sum", 64'(want.level_sum), 64'(got.level_sum));
    compare("low_level", 64'(want.low_level), 64'(got.low_level));
    compare("high_level", 64'(want.high_level), 64'(got.high_level));
    compare("level_range", 64'(want.level_range), 64'(got.level_range));
    compare("mean_level", 64'(want.mean_level), 64'(got.mean_level));
    compare("overflow", 64'(want.overflow), 64'(got.overflow));
    compare("last", 64'(want.last), 64'(got.last));
  endfunction
endclass

module testbench;
  localparam int PER_DAY_LIMIT  = 4096;
  localparam int RANDOM_ITEMS   = 220;
  localparam int WATCHDOG_LIMIT = 2000;

  logic                               clk;
  logic                               rst_n;
  logic                               in_valid;
  logic                               in_ready;
  logic        [dls_pkg::DAY_W-1:0]   in_day;
  logic        [dls_pkg::TIME_W-1:0]  in_time_of_day;
  logic signed [dls_pkg::LEVEL_W-1:0] in_level;
  logic                               in_end_of_data;
  logic                               out_valid;
  logic                               out_ready;
  logic        [dls_pkg::KIND_W-1:0]  out_kind;
  logic        [dls_pkg::DAY_W-1:0]   out_record_day;
  logic        [dls_pkg::TIME_W-1:0]  out_record_time;
  logic        [dls_pkg::OCNT_W-1:0]  out_sample_count;
  logic signed [dls_pkg::OSUM_W-1:0]  out_level_sum;
  logic signed [dls_pkg::LEVEL_W-1:0] out_low_level;
  logic signed [dls_pkg::LEVEL_W-1:0] out_high_level;
  logic        [dls_pkg::LEVEL_W-1:0] out_level_range;
  logic signed [dls_pkg::LEVEL_W-1:0] out_mean_level;
  logic                               out_overflow;
  logic                               out_last;

  day_stats_predictor predictor;
  day_record_t        got;
  bit                 steady;
  bit                 ended_clean;
  int                 sent;
  int                 rx_stall;
  int                 idle_run;

  daily_level_statistics #(
    .MAX_PER_DAY(PER_DAY_LIMIT)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_day           (in_day),
    .in_time_of_day   (in_time_of_day),
    .in_level         (in_level),
    .in_end_of_data   (in_end_of_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_record_day   (out_record_day),
    .out_record_time  (out_record_time),
    .out_sample_count (out_sample_count),
    .out_level_sum    (out_level_sum),
    .out_low_level    (out_low_level),
    .out_high_level   (out_high_level),
    .out_level_range  (out_level_range),
    .out_mean_level   (out_mean_level),
    .out_overflow     (out_overflow),
    .out_last         (out_last)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic int draw_wait();
    return steady ? 0 : $urandom_range(0, 16);
  endfunction

  // transfer monitor: feeds the predictor, checks results, tracks idle cycles
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      predictor.take_sample(in_day, in_time_of_day, in_level, in_end_of_data);
    if (rst_n && out_valid && out_ready) begin
      got.kind = dls_pkg::kind_t'(out_kind);
      got.record_day = out_record_day;
      got.record_time = out_record_time;
      got.sample_count = out_sample_count;
      got.level_sum = out_level_sum;
      got.low_level = out_low_level;
      got.high_level = out_high_level;
      got.level_range = out_level_range;
      got.mean_level = out_mean_level;
      got.overflow = out_overflow;
      got.last = out_last;
      predictor.check_record(got);
      rx_stall = draw_wait();
    end
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_run <= 0;
    else idle_run <= idle_run + 1;
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_stall > 0) begin
        out_ready = 1'b0;
        rx_stall--;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  initial begin
    do @(posedge clk); while (idle_run < WATCHDOG_LIMIT);
    $display("testbench: errors");
    $finish;
  end

  task automatic send_sample(input logic [dls_pkg::DAY_W-1:0] d,
                             input logic [dls_pkg::TIME_W-1:0] t,
                             input logic signed [dls_pkg::LEVEL_W-1:0] lvl,
                             input bit eod);
    int gap;
    gap = draw_wait();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_day = d;
    in_time_of_day = t;
    in_level = lvl;
    in_end_of_data = eod;
    do @(posedge clk); while (!in_ready);
    sent++;
    ended_clean = eod;
  endtask

  // one series of days; now and then the end marker is dropped so the
  // next series continues it
  task automatic random_series();
    int                                days;
    int                                per_day;
    bit                                drop_end;
    logic        [dls_pkg::DAY_W-1:0]   d;
    logic        [dls_pkg::TIME_W-1:0]  t;
    logic signed [dls_pkg::LEVEL_W-1:0] lvl;
    days = $urandom_range(1, 5);
    d = dls_pkg::DAY_W'($urandom);
    drop_end = ($urandom_range(0, 7) == 0);
    for (int k = 0; k < days; k++) begin
      per_day = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 8);
      t = dls_pkg::TIME_W'($urandom_range(0, 3600));
      for (int j = 0; j < per_day; j++) begin
        case ($urandom_range(0, 3))
          0: lvl = dls_pkg::LEVEL_W'($urandom_range(0, 20) - 10);
          1: lvl = ($urandom_range(0, 1) == 1) ? 16'sh7FFF : 16'sh8000;
          default: lvl = dls_pkg::LEVEL_W'($urandom);
        endcase
        if ($urandom_range(0, 7) == 0) t = dls_pkg::TIME_W'($urandom);
        send_sample(d, t, lvl, !drop_end && k == days - 1 && j == per_day - 1);
        t = dls_pkg::TIME_W'(t + $urandom_range(0, 5000));
      end
      d = ($urandom_range(0, 5) == 0) ? dls_pkg::DAY_W'($urandom) :
                                        dls_pkg::DAY_W'(d + $urandom_range(1, 3));
    end
  endtask

  initial begin
    predictor = new(PER_DAY_LIMIT);
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_day = '0;
    in_time_of_day = '0;
    in_level = '0;
    in_end_of_data = 1'b0;
    steady = 1'b0;
    ended_clean = 1'b1;
    sent = 0;
    rx_stall = 0;
    idle_run = 0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // first sample is also the end of data
    send_sample(16'hFFFF, 17'h1FFFF, 16'sh7FFF, 1'b1);
    // full level range in one day, ties on both extremes, day going back,
    // negative mean truncation, day change together with end of data
    send_sample(16'd0, 17'd0, 16'sh8000, 1'b0);
    send_sample(16'd0, 17'd5, 16'sh7FFF, 1'b0);
    send_sample(16'd0, 17'd10, 16'sh7FFF, 1'b0);
    send_sample(16'd0, 17'd20, 16'sh8000, 1'b0);
    send_sample(16'd3, 17'd100, 16'sd7, 1'b0);
    send_sample(16'd1, 17'd200, -16'sd7, 1'b0);
    send_sample(16'd1, 17'd300, -16'sd8, 1'b0);
    send_sample(16'd2, 17'd400, 16'sd5, 1'b1);
    // positive mean truncation, end of data within the same day
    send_sample(16'd9, 17'd86399, 16'sd3, 1'b0);
    send_sample(16'd9, 17'd86399, 16'sd4, 1'b1);
    // alternating bit patterns
    send_sample(16'h5555, 17'h0AAAA, 16'sh5555, 1'b0);
    send_sample(16'hAAAA, 17'h15555, 16'shAAAA, 1'b1);

    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) steady = !steady;
      random_series();
    end
    if (!ended_clean)
      send_sample(dls_pkg::DAY_W'($urandom), dls_pkg::TIME_W'($urandom),
                  dls_pkg::LEVEL_W'($urandom), 1'b1);
    @(negedge clk);
    in_valid = 1'b0;

    while (predictor.outstanding() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (predictor.mismatches == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end
endmodule
